// ----- rtl/core/sfr_pkg.sv -----
// Shared types, codes and the CRC-16 byte update for the sync frame receiver.
package sfr_pkg;

    localparam logic [7:0]  SYNC_BYTE      = 8'hAA;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [7:0]  DEV_ADDR_RESET = 8'h13;

    localparam logic [1:0] CMD_BYTE    = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [1:0] EV_GOOD = 2'd0;
    localparam logic [1:0] EV_BAD  = 2'd1;
    localparam logic [1:0] EV_READ = 2'd2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_FRAME,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [1:0]  ev;
        logic [7:0]  code;
        logic [7:0]  count;
        logic [15:0] crc;
        logic [7:0]  addr;
        logic [7:0]  data;
        logic        rd_ok;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/sync_frame_receiver_crc16_top.sv -----
// Top level of the sync-framed packet receiver with CRC-16 check.
// Throughput is one item per cycle; the parser stalls only when the four-entry queue is full.
// A result passes through the queue and is presented when the result register loads it.
// Payload reads take the registered read port of the payload memory in the back end.
// Synchronous active-low reset clears the parser, the pending flag, the queue and result valid.
// The payload memory is not cleared; reads of unwritten entries are masked to zero.
module sync_frame_receiver_crc16_top #(
    parameter int PAYLOAD_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_payload_count,
    output logic [15:0] o_received_crc,
    output logic [7:0]  o_read_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import sfr_pkg::*;

    t_item     push_item;
    t_item     head_item;
    t_q_status q_status;
    logic      push;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    sfr_front #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_rx_byte   (i_rx_byte),
        .i_read_index(i_read_index),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_item      (push_item)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_status(q_status)
    );

    sfr_back #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_item),
        .i_q_status     (q_status),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_event_res    (o_event_res),
        .o_command_code (o_command_code),
        .o_payload_count(o_payload_count),
        .o_received_crc (o_received_crc),
        .o_read_data    (o_read_data)
    );

    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res == EV_READ) |->
        (o_command_code == 8'd0 && o_payload_count == 8'd0 && o_received_crc == 16'd0))
        else $error("read result carries frame fields");

    a_frame_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_res == EV_GOOD || o_event_res == EV_BAD)) |->
        (o_read_data == 8'd0))
        else $error("frame result carries read data");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && q_status.empty))
        else $error("reset left a result or queue entry");

endmodule

// ----- rtl/core/sfr_front.sv -----
// Front end: accepts items, parses frame bytes, checks the CRC and queues operations.
module sfr_front #(
    parameter int PAYLOAD_DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_rx_byte,
    input  logic [7:0]        i_read_index,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_data,
    input  sfr_pkg::t_q_status i_q_status,
    output logic              o_push,
    output sfr_pkg::t_item    o_item
);
    import sfr_pkg::*;

    localparam logic [8:0] DEPTH9 = 9'(PAYLOAD_DEPTH);

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_ADDR,
        PH_LEN,
        PH_CMD,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_code, n_code;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi;
    logic        r_pending, n_pending;
    logic [7:0]  r_dev_addr;
    logic        accept;
    logic [15:0] crc_upd;
    logic [15:0] rx_crc;
    logic [7:0]  cnt_inc;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;
    assign crc_upd    = crc16_feed(r_crc, i_rx_byte);
    assign rx_crc     = {r_crc_hi, i_rx_byte};
    assign cnt_inc    = r_cnt + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_code    = r_code;
        n_crc     = r_crc;
        n_crc_hi  = r_crc_hi;
        n_pending = r_pending;
        o_push    = 1'b0;
        o_item    = '0;
        unique case (i_cmd)
            CMD_BYTE: begin
                unique case (r_phase)
                    PH_SYNC: begin
                        if (i_rx_byte == SYNC_BYTE && !r_pending) begin
                            n_crc   = CRC_INIT;
                            n_phase = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        if (i_rx_byte == r_dev_addr) begin
                            n_crc   = crc_upd;
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_len   = i_rx_byte;
                        n_crc   = crc_upd;
                        n_phase = PH_CMD;
                    end
                    PH_CMD: begin
                        n_code  = i_rx_byte;
                        n_crc   = crc_upd;
                        n_cnt   = 8'd0;
                        n_phase = (r_len == 8'd0) ? PH_CRC_HI : PH_DATA;
                    end
                    PH_DATA: begin
                        if ({1'b0, r_cnt} < DEPTH9) begin
                            o_push      = 1'b1;
                            o_item.op   = OP_WRITE;
                            o_item.addr = r_cnt;
                            o_item.data = i_rx_byte;
                        end
                        n_crc = crc_upd;
                        n_cnt = cnt_inc;
                        if (cnt_inc == r_len) begin
                            n_cnt   = 8'd0;
                            n_phase = PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI: begin
                        n_crc_hi = i_rx_byte;
                        n_phase  = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        o_push       = 1'b1;
                        o_item.op    = OP_FRAME;
                        o_item.ev    = (rx_crc == r_crc) ? EV_GOOD : EV_BAD;
                        o_item.code  = r_code;
                        o_item.count = r_len;
                        o_item.crc   = rx_crc;
                        n_pending    = (rx_crc == r_crc);
                        if (rx_crc != r_crc) begin
                            n_len  = 8'd0;
                            n_code = 8'd0;
                        end
                        n_cnt   = 8'd0;
                        n_phase = PH_SYNC;
                    end
                    default: begin
                        n_cnt   = 8'd0;
                        n_phase = PH_SYNC;
                    end
                endcase
            end
            CMD_RELEASE: begin
                n_pending = 1'b0;
            end
            CMD_READ: begin
                o_push       = 1'b1;
                o_item.op    = OP_READ;
                o_item.ev    = EV_READ;
                o_item.addr  = i_read_index;
                o_item.rd_ok = r_pending && (i_read_index < r_len)
                               && ({1'b0, i_read_index} < DEPTH9);
            end
            default: begin
            end
        endcase
        if (!accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC;
            r_cnt      <= 8'd0;
            r_len      <= 8'd0;
            r_code     <= 8'd0;
            r_crc      <= CRC_INIT;
            r_crc_hi   <= 8'd0;
            r_pending  <= 1'b0;
            r_dev_addr <= DEV_ADDR_RESET;
        end else begin
            if (accept) begin
                r_phase   <= n_phase;
                r_cnt     <= n_cnt;
                r_len     <= n_len;
                r_code    <= n_code;
                r_crc     <= n_crc;
                r_crc_hi  <= n_crc_hi;
                r_pending <= n_pending;
            end
            if (i_cfg_valid) begin
                r_dev_addr <= i_cfg_data;
            end
        end
    end

endmodule

// ----- rtl/core/sfr_queue.sv -----
// Short operation queue between the parser and the payload back end.
module sfr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sfr_pkg::t_item     i_item,
    input  logic               i_pop,
    output sfr_pkg::t_item     o_head,
    output sfr_pkg::t_q_status o_status
);
    import sfr_pkg::*;

    t_item           r_slot [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_status.full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/sfr_back.sv -----
// Back end: payload memory writes, payload reads and the registered result stage.
module sfr_back #(
    parameter int PAYLOAD_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfr_pkg::t_item     i_head,
    input  sfr_pkg::t_q_status i_q_status,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_event_res,
    output logic [7:0]         o_command_code,
    output logic [7:0]         o_payload_count,
    output logic [15:0]        o_received_crc,
    output logic [7:0]         o_read_data
);
    import sfr_pkg::*;

    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    logic [7:0]  r_mem [PAYLOAD_DEPTH];
    logic        r_valid;
    logic [1:0]  r_ev;
    logic [7:0]  r_code;
    logic [7:0]  r_count;
    logic [15:0] r_crc;
    logic        r_rd_ok;
    logic [7:0]  r_rd_data;
    logic        load;
    logic        wr_en;

    assign load  = !i_q_status.empty && (i_head.op != OP_WRITE)
                   && (!r_valid || i_out_ready);
    assign wr_en = !i_q_status.empty && (i_head.op == OP_WRITE);
    assign o_pop = load || wr_en;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_head.addr[AW-1:0]] <= i_head.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head.op == OP_READ) begin
            r_rd_data <= r_mem[i_head.addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ev    <= i_head.ev;
            r_code  <= i_head.code;
            r_count <= i_head.count;
            r_crc   <= i_head.crc;
            r_rd_ok <= (i_head.op == OP_READ) && i_head.rd_ok;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_event_res     = r_ev;
    assign o_command_code  = r_code;
    assign o_payload_count = r_count;
    assign o_received_crc  = r_crc;
    assign o_read_data     = r_rd_ok ? r_rd_data : 8'd0;

endmodule

// ----- bench/tb.sv -----
// Testbench for the sync-framed packet receiver: directed table, random frames, live predictor.
`timescale 1ns / 100ps

module tb;
    import sfr_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 120;
    localparam int BURST_READS   = 24;
    localparam int PHASES        = 8;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int TIMEOUT_NS    = 2000000;
    localparam int STORE_DEPTH   = 256;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        PH_SYNC,
        PH_ADDR,
        PH_LEN,
        PH_CMD,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO
    } t_parse_phase;

    typedef enum logic [1:0] {
        ROW_LITERAL,
        ROW_CRC_HIGH,
        ROW_CRC_LOW,
        ROW_CRC_CORRUPT
    } t_row_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  code;
        logic [7:0]  count;
        logic [15:0] crc;
        logic [7:0]  data;
    } t_rx_event;

    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] cmd;
        logic [7:0] value;
        logic [7:0] idx;
        logic       typed;
        t_rx_event  result;
    } t_stim_row;

    localparam t_rx_event READ_ZERO = '{EV_READ, 8'h00, 8'h00, 16'h0000, 8'h00};
    localparam t_rx_event NO_EVENT  = '{EV_GOOD, 8'h00, 8'h00, 16'h0000, 8'h00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd = CMD_BYTE;
    logic [7:0]  i_rx_byte = 8'h00;
    logic [7:0]  i_read_index = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_event_res;
    logic [7:0]  o_command_code;
    logic [7:0]  o_payload_count;
    logic [15:0] o_received_crc;
    logic [7:0]  o_read_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = 8'h00;

    sync_frame_receiver_crc16_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_rx_byte       (i_rx_byte),
        .i_read_index    (i_read_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_event_res     (o_event_res),
        .o_command_code  (o_command_code),
        .o_payload_count (o_payload_count),
        .o_received_crc  (o_received_crc),
        .o_read_data     (o_read_data),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_parse_phase pr_phase = PH_SYNC;
    logic [7:0]   pr_address = DEV_ADDR_RESET;
    logic [7:0]   pr_len = 8'h00;
    logic [7:0]   pr_code = 8'h00;
    logic [7:0]   pr_count = 8'h00;
    logic [15:0]  pr_crc = CRC_INIT;
    logic [7:0]   pr_crc_hi = 8'h00;
    logic         pr_pending = 1'b0;
    logic [7:0]   pr_store [STORE_DEPTH];

    t_rx_event awaited_events [$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        hold_req = 0;
    int        hold_seen = 0;
    int        hold_left = 0;

    t_stim_row directed_rows [23] = '{
        '{ROW_LITERAL,     CMD_READ,    8'h00, 8'h00, 1'b1, READ_ZERO},
        '{ROW_LITERAL,     CMD_RELEASE, 8'h00, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_UNUSED,  8'hFF, 8'hFF, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'hAA, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'h55, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'h13, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'h02, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'hFF, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'h00, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'hFF, 8'h00, 1'b0, NO_EVENT},
        '{ROW_CRC_HIGH,    CMD_BYTE,    8'h00, 8'h00, 1'b0, NO_EVENT},
        '{ROW_CRC_LOW,     CMD_BYTE,    8'h00, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'hAA, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_READ,    8'h00, 8'h01, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_READ,    8'h00, 8'hFF, 1'b1, READ_ZERO},
        '{ROW_LITERAL,     CMD_RELEASE, 8'hFF, 8'hFF, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'hAA, 8'hFF, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'h13, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'h00, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_BYTE,    8'h00, 8'h00, 1'b0, NO_EVENT},
        '{ROW_CRC_HIGH,    CMD_BYTE,    8'h00, 8'h00, 1'b0, NO_EVENT},
        '{ROW_CRC_CORRUPT, CMD_BYTE,    8'h00, 8'h00, 1'b0, NO_EVENT},
        '{ROW_LITERAL,     CMD_READ,    8'h00, 8'h00, 1'b1, READ_ZERO}
    };

    logic [7:0] address_plan [PHASES] = '{8'h00, 8'hFF, 8'hAA, 8'h13, 8'h5C, 8'h01, 8'hE7, 8'h80};

    function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic parse_item(input logic [1:0] cmd, input logic [7:0] b, input logic [7:0] idx,
                              output bit has, output t_rx_event ev);
        logic [15:0] rx;
        has = 1'b0;
        ev = NO_EVENT;
        case (cmd)
            CMD_BYTE: begin
                case (pr_phase)
                    PH_SYNC: begin
                        if (b == SYNC_BYTE && !pr_pending) begin
                            pr_crc = CRC_INIT;
                            pr_phase = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        if (b == pr_address) begin
                            pr_crc = crc_ccitt_byte(pr_crc, b);
                            pr_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        pr_len = b;
                        pr_crc = crc_ccitt_byte(pr_crc, b);
                        pr_phase = PH_CMD;
                    end
                    PH_CMD: begin
                        pr_code = b;
                        pr_crc = crc_ccitt_byte(pr_crc, b);
                        pr_count = 8'h00;
                        pr_phase = (pr_len == 8'h00) ? PH_CRC_HI : PH_DATA;
                    end
                    PH_DATA: begin
                        pr_store[pr_count] = b;
                        pr_crc = crc_ccitt_byte(pr_crc, b);
                        pr_count = pr_count + 8'h01;
                        if (pr_count == pr_len) begin
                            pr_count = 8'h00;
                            pr_phase = PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI: begin
                        pr_crc_hi = b;
                        pr_phase = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        rx = {pr_crc_hi, b};
                        has = 1'b1;
                        ev.kind = (rx == pr_crc) ? EV_GOOD : EV_BAD;
                        ev.code = pr_code;
                        ev.count = pr_len;
                        ev.crc = rx;
                        pr_pending = (rx == pr_crc);
                        if (!pr_pending) begin
                            pr_len = 8'h00;
                            pr_code = 8'h00;
                        end
                        pr_count = 8'h00;
                        pr_phase = PH_SYNC;
                    end
                    default: begin
                        pr_count = 8'h00;
                        pr_phase = PH_SYNC;
                    end
                endcase
            end
            CMD_RELEASE: begin
                pr_pending = 1'b0;
            end
            CMD_READ: begin
                has = 1'b1;
                ev.kind = EV_READ;
                if (pr_pending && idx < pr_len) begin
                    ev.data = pr_store[idx];
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got, input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic check_result();
        t_rx_event want;
        if (awaited_events.size() == 0) begin
            report_mismatch($sformatf("unexpected result, event %0d", o_event_res));
            return;
        end
        want = awaited_events.pop_front();
        compare_field("event_res", 16'(o_event_res), 16'(want.kind));
        compare_field("command_code", 16'(o_command_code), 16'(want.code));
        compare_field("payload_count", 16'(o_payload_count), 16'(want.count));
        compare_field("received_crc", o_received_crc, want.crc);
        compare_field("read_data", 16'(o_read_data), 16'(want.data));
    endtask

    // Result checking and the receiver side of the output handshake.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            check_result();
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] b, input logic [7:0] idx,
                             input bit typed, input t_rx_event typed_ev);
        bit        has;
        t_rx_event ev;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd <= cmd;
        i_rx_byte <= b;
        i_read_index <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        parse_item(cmd, b, idx, has, ev);
        if (typed) begin
            awaited_events.push_back(typed_ev);
        end else if (has) begin
            awaited_events.push_back(ev);
        end
        if (cmd != CMD_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic put(input logic [1:0] cmd, input logic [7:0] b, input logic [7:0] idx);
        send_item(cmd, b, idx, 1'b0, NO_EVENT);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [7:0] a);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= a;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pr_address = a;
    endtask

    task automatic random_traffic(input int target);
        int         stop_at;
        int         len;
        int         n;
        int         roll;
        logic [7:0] b;
        logic [7:0] mask;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 65) begin
                if (pr_pending && $urandom_range(99) < 85) begin
                    put(CMD_RELEASE, 8'($urandom), 8'($urandom));
                end
                put(CMD_BYTE, SYNC_BYTE, 8'($urandom));
                n = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : 0;
                repeat (n) begin
                    b = 8'($urandom);
                    if (b == pr_address) begin
                        b = b ^ 8'h01;
                    end
                    put(CMD_BYTE, b, 8'($urandom));
                end
                roll = $urandom_range(99);
                len = (roll < 88) ? $urandom_range(0, 8) :
                      (roll < 97) ? $urandom_range(9, 40) : $urandom_range(200, 255);
                put(CMD_BYTE, pr_address, 8'($urandom));
                put(CMD_BYTE, 8'(len), 8'($urandom));
                put(CMD_BYTE, 8'($urandom), 8'($urandom));
                for (int k = 0; k < len; k++) begin
                    put(CMD_BYTE, 8'($urandom), 8'($urandom));
                end
                roll = $urandom_range(99);
                mask = (roll < 80) ? 8'h00 : 8'($urandom_range(1, 255));
                put(CMD_BYTE, pr_crc[15:8] ^ ((roll < 90) ? mask : 8'h00), 8'($urandom));
                put(CMD_BYTE, pr_crc[7:0] ^ ((roll < 90) ? 8'h00 : mask), 8'($urandom));
                if ($urandom_range(99) < 60) begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        b = (len > 0 && $urandom_range(3) != 0) ? 8'($urandom_range(len - 1))
                                                                 : 8'($urandom);
                        put(CMD_READ, 8'($urandom), b);
                    end
                end
            end else if (roll < 85) begin
                if ($urandom_range(4) == 0) begin
                    put(CMD_RELEASE, 8'($urandom), 8'($urandom));
                end else begin
                    put(CMD_READ, 8'($urandom), 8'($urandom));
                end
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) put(2'($urandom), 8'($urandom), 8'($urandom));
                while (pr_phase != PH_SYNC) put(CMD_BYTE, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        logic [7:0] v;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_CRC_HIGH:    v = pr_crc[15:8];
                ROW_CRC_LOW:     v = pr_crc[7:0];
                ROW_CRC_CORRUPT: v = ~pr_crc[7:0];
                default:         v = directed_rows[r].value;
            endcase
            send_item(directed_rows[r].cmd, v, directed_rows[r].idx,
                      directed_rows[r].typed, directed_rows[r].result);
        end
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_address(address_plan[ph]);
            case (ph % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 70;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 70;
                end
                default: begin
                    tx_idle_pct = 27;
                    rx_stall_pct = 27;
                end
            endcase
            if (ph == 0) begin
                // The output side holds off while reads keep coming, so the input stalls.
                hold_req++;
                repeat (BURST_READS) put(CMD_READ, 8'($urandom), 8'($urandom));
                drain();
            end
            random_traffic(RANDOM_ITEMS / PHASES);
            drain();
        end

        if (mismatches == 0) begin
            $display("** sync_frame_receiver_crc16_top: PASSED **");
        end else begin
            $display("** sync_frame_receiver_crc16_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("[%0t] timeout with %0d results outstanding", $time, awaited_events.size());
        $display("** sync_frame_receiver_crc16_top: FAILED **");
        $finish;
    end

endmodule
